// File: rtl/sas_pkg.sv
// Shared types for the sort and statistics block: controller states and the
// command and status bundles between controller and datapath. No dependencies.
package sas_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SORT_CHK,
    S_KEY,
    S_CMP,
    S_INS,
    S_DIV,
    S_DIV_WAIT,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic sort_init;
    logic rd_key;
    logic key_cap;
    logic shift;
    logic place;
    logic div_start;
    logic pass_init;
    logic pass_emit;
    logic pass_rd;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic i_lt_n;
    logic j_gt1;
    logic gt;
    logic div_idle;
    logic k_lt_n;
  } status_t;

endpackage

// File: rtl/sas_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sas_div.sv
// Bit-serial signed divider for the mean: (sum * 2^16) / n, truncated toward
// zero, one quotient bit per cycle. No dependencies.
module sas_div #(
  parameter int SW = 22,
  parameter int CW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [SW-1:0] sum,
  input  logic [CW-1:0] divisor,
  output logic          busy,
  output logic [31:0]   mean
);

  localparam int DW = SW + 16;
  localparam int NW = $clog2(DW + 1);

  logic [DW-1:0] q_r, q_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          neg_r, neg_nxt;
  logic [SW-1:0] mag;
  logic [CW:0]   rem_sh;
  logic [CW:0]   rem_sub;
  logic [DW-1:0] q_signed;
  logic [DW+31:0] q_ext;

  assign mag     = sum[SW-1] ? (~sum + 1'b1) : sum;
  assign rem_sh  = {rem_r, q_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    if (start) begin
      q_nxt    = {mag, 16'b0};
      rem_nxt  = '0;
      cnt_nxt  = NW'(DW);
      busy_nxt = 1'b1;
      neg_nxt  = sum[SW-1];
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem_nxt = rem_sub[CW-1:0];
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[CW-1:0];
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == NW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign q_signed = neg_r ? (~q_r + 1'b1) : q_r;
  assign q_ext    = {{32{q_signed[DW-1]}}, q_signed};
  assign mean     = q_ext[31:0];
  assign busy     = busy_r;

endmodule

// File: rtl/sas_ctrl.sv
// Controller for the sort and statistics block: load, insertion sort, divide,
// scan and emit phases. Depends on sas_pkg.
module sas_ctrl
  import sas_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    final_item,
  input  status_t st,
  output logic    busy,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (accept && final_item) state_nxt = S_SORT_CHK;
      S_SORT_CHK: state_nxt = st.i_lt_n ? S_KEY : S_DIV;
      S_KEY:      state_nxt = S_CMP;
      S_CMP: begin
        if (st.gt) begin
          state_nxt = st.j_gt1 ? S_CMP : S_INS;
        end else begin
          state_nxt = S_SORT_CHK;
        end
      end
      S_INS:      state_nxt = S_SORT_CHK;
      S_DIV:      state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (st.div_idle) state_nxt = S_SCAN;
      S_SCAN:     if (!st.k_lt_n) state_nxt = S_EMIT;
      S_EMIT:     if (!st.k_lt_n) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load      = accept;
        cmd.sort_init = accept && final_item;
      end
      S_SORT_CHK: cmd.rd_key = 1'b1;
      S_KEY:      cmd.key_cap = 1'b1;
      S_CMP: begin
        cmd.shift = st.gt;
        cmd.place = !st.gt;
      end
      S_INS:      cmd.place = 1'b1;
      S_DIV:      cmd.div_start = 1'b1;
      S_DIV_WAIT: cmd.pass_init = st.div_idle;
      S_SCAN: begin
        cmd.pass_rd   = st.k_lt_n;
        cmd.pass_init = !st.k_lt_n;
        cmd.pass_emit = !st.k_lt_n;
      end
      S_EMIT: begin
        cmd.pass_rd = st.k_lt_n;
        cmd.clear   = !st.k_lt_n;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/sas_dp.sv
// Datapath: value store, sort indexes, running sum, divider, scan statistics
// and result registers. Depends on sas_pkg, sas_ram and sas_div.
module sas_dp
  import sas_pkg::*;
#(
  parameter int MAX_ITEMS   = 32,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  input  logic signed [VALUE_WIDTH-1:0] in_sample_value,
  output status_t                       st,
  output logic                          out_strobe,
  output logic signed [VALUE_WIDTH-1:0] out_sorted_value,
  output logic                          out_end_of_run,
  output logic signed [22:0]            out_total_sum,
  output logic signed [31:0]            out_mean_fixed,
  output logic signed [16:0]            out_median_doubled,
  output logic [6:0]                    out_distinct_count,
  output logic [5:0]                    out_repeat_count,
  output logic                          out_overflow_flag
);

  localparam int VW = VALUE_WIDTH;
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = VW + CW;

  logic [CW-1:0] fill_r, i_r, j_r, k_r, kd_r, dist_r;
  logic [SW-1:0] sum_r;
  logic          ovf_r, pend_r, emit_r;
  logic signed [VW-1:0] key_r, prev_r, mlo_r, mhi_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rdata_raw;
  logic signed [VW-1:0] rdata;
  logic          div_busy;
  logic [31:0]   mean;
  logic [CW-1:0] half, jm1, jm2, rep;
  logic          last;
  logic [VW:0]   med;
  logic [SW+22:0] sum_ext;
  logic [VW+17:0] med_ext;
  logic [CW+6:0]  dist_ext;
  logic [CW+5:0]  rep_ext;

  assign rdata = $signed(rdata_raw);
  assign jm1   = j_r - 1'b1;
  assign jm2   = j_r - 2'd2;
  assign half  = fill_r >> 1;
  assign last  = pend_r && emit_r && (kd_r == fill_r - 1'b1);

  always_comb begin
    we    = 1'b0;
    waddr = j_r[AW-1:0];
    wdata = key_r;
    if (cmd.load) begin
      we    = (fill_r < CW'(MAX_ITEMS));
      waddr = fill_r[AW-1:0];
      wdata = in_sample_value;
    end else if (cmd.shift) begin
      we    = 1'b1;
      wdata = rdata;
    end else if (cmd.place) begin
      we    = 1'b1;
    end
  end

  always_comb begin
    raddr = k_r[AW-1:0];
    if (cmd.rd_key) begin
      raddr = i_r[AW-1:0];
    end else if (cmd.key_cap) begin
      raddr = i_r[AW-1:0] - 1'b1;
    end else if (cmd.shift) begin
      raddr = jm2[AW-1:0];
    end
  end

  sas_ram #(.WIDTH(VW), .DEPTH(MAX_ITEMS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  sas_div #(.SW(SW), .CW(CW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .sum    (sum_r),
    .divisor(fill_r),
    .busy   (div_busy),
    .mean   (mean)
  );

  assign st.i_lt_n   = (i_r < fill_r);
  assign st.j_gt1    = (j_r > CW'(1));
  assign st.gt       = (rdata > key_r);
  assign st.div_idle = !div_busy;
  assign st.k_lt_n   = (k_r < fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
      ovf_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.pass_rd;
      if (cmd.clear) begin
        fill_r <= '0;
        sum_r  <= '0;
        ovf_r  <= 1'b0;
      end else if (cmd.load) begin
        if (fill_r < CW'(MAX_ITEMS)) begin
          fill_r <= fill_r + 1'b1;
          sum_r  <= sum_r + {{CW{in_sample_value[VW-1]}}, in_sample_value};
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      i_r <= CW'(1);
    end else if (cmd.place) begin
      i_r <= i_r + 1'b1;
    end
    if (cmd.key_cap) begin
      key_r <= rdata;
      j_r   <= i_r;
    end else if (cmd.shift) begin
      j_r <= jm1;
    end
    if (cmd.pass_init) begin
      k_r    <= '0;
      emit_r <= cmd.pass_emit;
    end else if (cmd.pass_rd) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.pass_rd) begin
      kd_r <= k_r;
    end
    if (cmd.pass_init && !cmd.pass_emit) begin
      dist_r <= '0;
    end else if (pend_r && !emit_r) begin
      if (kd_r == '0 || rdata != prev_r) begin
        dist_r <= dist_r + 1'b1;
      end
      prev_r <= rdata;
      if (kd_r == half - 1'b1) mlo_r <= rdata;
      if (kd_r == half) mhi_r <= rdata;
    end
  end

  assign med      = fill_r[0] ? {mhi_r, 1'b0}
                              : ({mlo_r[VW-1], mlo_r} + {mhi_r[VW-1], mhi_r});
  assign rep      = fill_r - dist_r;
  assign sum_ext  = {{23{sum_r[SW-1]}}, sum_r};
  assign med_ext  = {{17{med[VW]}}, med};
  assign dist_ext = {7'b0, dist_r};
  assign rep_ext  = {6'b0, rep};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= pend_r && emit_r;
    end
    out_sorted_value   <= rdata;
    out_end_of_run     <= last;
    out_total_sum      <= last ? sum_ext[22:0] : '0;
    out_mean_fixed     <= last ? mean : '0;
    out_median_doubled <= last ? med_ext[16:0] : '0;
    out_distinct_count <= last ? dist_ext[6:0] : '0;
    out_repeat_count   <= last ? rep_ext[5:0] : '0;
    out_overflow_flag  <= last ? ovf_r : 1'b0;
  end

endmodule

// File: rtl/sort_and_array_statistics_top.sv
// Top level of the sort and statistics block: controller plus datapath.
// Depends on sas_pkg, sas_ctrl and sas_dp (with sas_ram and sas_div).
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------
//   input   | start / busy          | in_sample_value, in_final_item
//   result  | out_strobe            | out_sorted_value .. out_overflow_flag
//
// A non-final value is taken whenever start is high while busy is low. After the
// final value the block is busy for the insertion sort through the single RAM
// read port, then for the bit-serial mean divider, the statistics scan and the
// emit phase; n results come one per cycle, the last on the first idle cycle,
// and the receiver cannot stall them.
// Reset is synchronous, active low, and clears the fill count, sum and flags.
module sort_and_array_statistics_top
  import sas_pkg::*;
#(
  parameter int MAX_ITEMS   = 32,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] in_sample_value,
  input  logic                          in_final_item,
  output logic                          out_strobe,
  output logic signed [VALUE_WIDTH-1:0] out_sorted_value,
  output logic                          out_end_of_run,
  output logic signed [22:0]            out_total_sum,
  output logic signed [31:0]            out_mean_fixed,
  output logic signed [16:0]            out_median_doubled,
  output logic [6:0]                    out_distinct_count,
  output logic [5:0]                    out_repeat_count,
  output logic                          out_overflow_flag
);

  cmd_t    cmd;
  status_t st;

  sas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .final_item(in_final_item),
    .st        (st),
    .busy      (busy),
    .cmd       (cmd)
  );

  sas_dp #(.MAX_ITEMS(MAX_ITEMS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_sample_value   (in_sample_value),
    .st                (st),
    .out_strobe        (out_strobe),
    .out_sorted_value  (out_sorted_value),
    .out_end_of_run    (out_end_of_run),
    .out_total_sum     (out_total_sum),
    .out_mean_fixed    (out_mean_fixed),
    .out_median_doubled(out_median_doubled),
    .out_distinct_count(out_distinct_count),
    .out_repeat_count  (out_repeat_count),
    .out_overflow_flag (out_overflow_flag)
  );

`ifndef SYNTHESIS
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy)) else $error("result outside a busy phase");
  a_end_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_end_of_run |-> out_strobe) else $error("end of run without strobe");
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_end_of_run |=> out_strobe) else $error("result burst gap");
  a_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_end_of_run |=> !out_strobe) else $error("result after end of run");
`endif

endmodule
